@@ hw/rtl/bht_pkg.sv @@
// Shared types and constants for the bucketed hash table.
// Holds table geometry, request and status codes, and memory row layouts.
// No dependencies.
package bht_pkg;

  localparam int BUCKET_COUNT = 16;
  localparam int BUCKET_WAYS  = 4;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int BKT_W   = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

  // floor(2^32 / BUCKET_COUNT), used for the reciprocal bucket reduction
  localparam logic [KEY_W:0]   HASH_RECIP = (KEY_W + 1)'((65'd1 << KEY_W) / BUCKET_COUNT);
  localparam logic [KEY_W-1:0] NB_WORD    = KEY_W'(BUCKET_COUNT);

  localparam logic [VAL_W-1:0] MOST_NEG = {1'b1, {(VAL_W - 1){1'b0}}};

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // One bucket of the key memory: a valid mark and a key per way
  typedef struct packed {
    logic [BUCKET_WAYS-1:0]            valid;
    logic [BUCKET_WAYS-1:0][KEY_W-1:0] keys;
  } key_row_t;

  // One bucket of the value memory
  typedef logic [BUCKET_WAYS-1:0][VAL_W-1:0] val_row_t;

endpackage

@@ hw/rtl/bht_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module bht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/bucketed_hash_table_top.sv @@
// Top level of the bucketed key/value hash table.
// Depends on bht_pkg and bht_ram (key/valid memory and value memory).
//
//  channel   ports                          handshake
//  --------  -----------------------------  -----------------------------------
//  request   req_type, key, value           transfer when start && !busy
//  result    status, found, read_value      done high for one cycle, no stall
//
// A request passes three bucket-reduction steps (HASH1 to HASH3), one
// bucket-row read and one compare-and-write before its result strobe rises.
// busy drops with the strobe, so the next transfer can come at the edge
// that ends the result cycle. After reset, busy stays high while the sweep
// clears every valid mark, one bucket per cycle. The receiver cannot stall.
module bucketed_hash_table_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 req_type,
  input  logic signed [bht_pkg::KEY_W-1:0] key,
  input  logic signed [bht_pkg::VAL_W-1:0] value,
  output logic                       done,
  output logic [1:0]                 status,
  output logic                       found,
  output logic signed [bht_pkg::VAL_W-1:0] read_value
);

  import bht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH1,
    S_HASH2,
    S_HASH3,
    S_READ,
    S_UPDATE
  } state_t;

  state_t state;

  // Request registers
  op_t              req_op;
  logic [KEY_W-1:0] req_key;
  logic [VAL_W-1:0] req_val;

  // Bucket reduction pipeline
  logic [KEY_W-1:0] mag;
  logic [2*KEY_W:0] prod1;
  logic [KEY_W-1:0] prod2;
  logic [KEY_W-1:0] rem;
  logic [KEY_W-1:0] rem_adj;
  logic [BKT_W-1:0] bucket;
  logic [BKT_W-1:0] clr_idx;

  // Memory ports
  logic     key_we;
  logic [BKT_W-1:0] key_waddr;
  key_row_t key_wdata;
  key_row_t key_rdata;
  logic     val_we;
  val_row_t val_rdata;

  // Compare-and-modify results
  logic [BUCKET_WAYS-1:0] match;
  logic [BUCKET_WAYS-1:0] free_oh;
  logic                   hit;
  logic                   has_free;
  logic [VAL_W-1:0]       hit_val;
  key_row_t               key_row_next;
  val_row_t               val_row_next;
  status_t                status_next;
  logic [VAL_W-1:0]       read_value_next;

  assign busy = (state != S_IDLE);

  // Remainder correction: the reciprocal estimate is at most one below the quotient
  assign rem     = mag - prod2;
  assign rem_adj = (rem >= NB_WORD) ? (rem - NB_WORD) : rem;

  // Key memory: written by the clearing sweep and by the update cycle
  assign key_we    = (state == S_CLEAR) || (state == S_UPDATE);
  assign key_waddr = (state == S_CLEAR) ? clr_idx : bucket;
  assign key_wdata = (state == S_CLEAR) ? '0 : key_row_next;
  assign val_we    = (state == S_UPDATE);

  bht_ram #(
    .WIDTH ($bits(key_row_t)),
    .DEPTH (BUCKET_COUNT)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (bucket),
    .rdata (key_rdata)
  );

  bht_ram #(
    .WIDTH ($bits(val_row_t)),
    .DEPTH (BUCKET_COUNT)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (bucket),
    .wdata (val_row_next),
    .raddr (bucket),
    .rdata (val_rdata)
  );

  // Search the bucket row, pick the lowest free way, and build the write-back rows
  always_comb begin
    logic taken;
    taken   = 1'b0;
    hit_val = '0;
    free_oh = '0;
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      match[w] = key_rdata.valid[w] && (key_rdata.keys[w] == req_key);
      if (match[w]) begin
        hit_val = hit_val | val_rdata[w];
      end
      if (!key_rdata.valid[w] && !taken) begin
        free_oh[w] = 1'b1;
        taken      = 1'b1;
      end
    end
    hit      = |match;
    has_free = taken;

    key_row_next    = key_rdata;
    val_row_next    = val_rdata;
    status_next     = ST_OK;
    read_value_next = MOST_NEG;

    case (req_op)
      OP_INSERT: begin
        if (hit) begin
          status_next = ST_PRESENT;
        end else if (has_free) begin
          for (int w = 0; w < BUCKET_WAYS; w++) begin
            if (free_oh[w]) begin
              key_row_next.valid[w] = 1'b1;
              key_row_next.keys[w]  = req_key;
              val_row_next[w]       = req_val;
            end
          end
        end else begin
          status_next = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          key_row_next.valid = key_rdata.valid & ~match;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_GET: begin
        if (hit) begin
          read_value_next = hit_val;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_UPDATE: begin
        if (hit) begin
          for (int w = 0; w < BUCKET_WAYS; w++) begin
            if (match[w]) begin
              val_row_next[w] = req_val;
            end
          end
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      default: begin
        status_next = ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          // Sweep every bucket once, then open for requests
          if (clr_idx == BKT_W'(BUCKET_COUNT - 1)) begin
            state <= S_IDLE;
          end
          clr_idx <= clr_idx + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            req_op  <= op_t'(req_type);
            req_key <= key;
            req_val <= value;
            // Magnitude as unsigned; the most negative key stays 2^31
            mag     <= key[KEY_W-1] ? (~key + 1'b1) : key;
            state   <= S_HASH1;
          end
        end
        S_HASH1: begin
          prod1 <= (2*KEY_W + 1)'(mag) * (2*KEY_W + 1)'(HASH_RECIP);
          state <= S_HASH2;
        end
        S_HASH2: begin
          prod2 <= prod1[2*KEY_W-1:KEY_W] * NB_WORD;
          state <= S_HASH3;
        end
        S_HASH3: begin
          bucket <= rem_adj[BKT_W-1:0];
          state  <= S_READ;
        end
        S_READ: begin
          // Row read is in flight; data lands for the update cycle
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          done       <= 1'b1;
          status     <= status_next;
          found      <= hit;
          read_value <= read_value_next;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/bht_checker.sv @@
// Port-level checker for the bucketed hash table, with its bind statement.
// Depends on bht_pkg and the ports of bucketed_hash_table_top.
module bht_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       busy,
  input logic                       done,
  input logic [1:0]                 status,
  input logic                       found,
  input logic signed [bht_pkg::VAL_W-1:0] read_value
);

  import bht_pkg::*;

  // A result follows a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding busy cycle");

  // Results never come back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // A miss always returns the most negative value
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (read_value == MOST_NEG))
    else $error("read_value not most negative on a miss");

  // A present key never reports not found or full
  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (status != ST_NOT_FOUND && status != ST_FULL))
    else $error("status contradicts found");

  // A missing key never reports already present
  a_miss_status: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (status != ST_PRESENT))
    else $error("already present reported for a missing key");

endmodule

bind bucketed_hash_table_top bht_checker u_bht_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the bucketed key/value hash table (bucketed_hash_table_top).
// Depends on bht_pkg for geometry, request codes and status codes.
module testbench;
  import bht_pkg::*;

  // One queued request; wait_idle holds it back until every pending result is in
  typedef struct {
    op_t                     op;
    logic signed [KEY_W-1:0] k;
    logic signed [VAL_W-1:0] v;
    bit                      wait_idle;
  } lookup_req_t;

  // One predicted reply of the table
  typedef struct {
    status_t                 st;
    logic                    hit;
    logic signed [VAL_W-1:0] rd;
  } lookup_reply_t;

  localparam int SLOTS = BUCKET_COUNT * BUCKET_WAYS;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [1:0]              req_type = OP_GET;
  logic signed [KEY_W-1:0] key = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic                    busy;
  logic                    done;
  logic [1:0]              status;
  logic                    found;
  logic signed [VAL_W-1:0] read_value;

  bucketed_hash_table_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .key       (key),
    .value     (value),
    .done      (done),
    .status    (status),
    .found     (found),
    .read_value(read_value)
  );

  // Shadow copy of the table. Keys and values are only read where the
  // occupied mark is set, so their initial contents never matter.
  logic [KEY_W-1:0] shadow_key [SLOTS];
  logic [VAL_W-1:0] shadow_val [SLOTS];
  bit               shadow_used[SLOTS];

  lookup_req_t   request_q[$];     // requests not yet transferred
  lookup_reply_t expected_replies[$];  // replies predicted, not yet seen
  lookup_req_t   in_flight;        // request currently on the input ports

  int error_count = 0;
  int sent_count = 0;
  int reply_count = 0;
  int op_count[4];
  int status_count[4];
  int hit_count = 0;

  // Sender pacing state
  int gap_left = 0;
  int stretch_left = 0;
  bit quiet_stretch = 1'b0;
  logic start_next;

  logic signed [KEY_W-1:0] key_pool[48];

  // Clock: 10 ns period
  initial begin
    forever #5 clk = ~clk;
  end

  // Reset: asserted from time zero, then released for good
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Bucket of a signed key: magnitude as unsigned 32 bits, modulo the bucket count.
  // The most negative key wraps to itself, which is magnitude 2^31 unsigned.
  function automatic int unsigned bucket_of_key(logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] mag;
    mag = k[KEY_W-1] ? (KEY_W'(0) - k) : k;
    return mag % BUCKET_COUNT;
  endfunction

  // Apply one request to the shadow table and return the reply it must produce.
  function automatic lookup_reply_t apply_to_shadow(lookup_req_t r);
    lookup_reply_t res;
    int unsigned   base;
    int            hit_slot;
    base = bucket_of_key(r.k) * BUCKET_WAYS;
    hit_slot = -1;
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      if (hit_slot < 0 && shadow_used[base + w] && shadow_key[base + w] == r.k)
        hit_slot = base + w;
    end
    res.hit = (hit_slot >= 0);
    res.rd = MOST_NEG;
    res.st = ST_OK;
    if (r.op == OP_INSERT) begin
      if (hit_slot >= 0) begin
        res.st = ST_PRESENT;
      end else begin
        // Take the lowest free way; report full when none is left
        res.st = ST_FULL;
        for (int w = 0; w < BUCKET_WAYS; w++) begin
          if (res.st == ST_FULL && !shadow_used[base + w]) begin
            shadow_used[base + w] = 1'b1;
            shadow_key[base + w] = r.k;
            shadow_val[base + w] = r.v;
            res.st = ST_OK;
          end
        end
      end
    end else if (hit_slot < 0) begin
      res.st = ST_NOT_FOUND;
    end else begin
      case (r.op)
        OP_REMOVE: begin
          shadow_used[hit_slot] = 1'b0;
        end
        OP_GET: begin
          res.rd = shadow_val[hit_slot];
        end
        OP_UPDATE: begin
          shadow_val[hit_slot] = r.v;
        end
        default: begin
        end
      endcase
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    error_count++;
  endtask

  task automatic queue_request(input op_t op, input logic signed [KEY_W-1:0] k,
                               input logic signed [VAL_W-1:0] v, input bit wait_idle);
    lookup_req_t r;
    r.op = op;
    r.k = k;
    r.v = v;
    r.wait_idle = wait_idle;
    request_q = {request_q, r};
  endtask

  // Gap after a transfer: mostly none or short, now and then long.
  // Stretches of requests run back to back with no gap at all.
  function automatic int pick_gap();
    int roll;
    if (stretch_left == 0) begin
      stretch_left = $urandom_range(20, 80);
      quiet_stretch = ($urandom_range(0, 3) == 0);
    end
    stretch_left--;
    if (quiet_stretch)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Driver: predict each request at its transfer, then present the next one
  // once its gap has run out. start is assigned exactly once per edge.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      start_next = start;
      if (start && !busy) begin
        expected_replies = {expected_replies, apply_to_shadow(in_flight)};
        op_count[in_flight.op]++;
        sent_count++;
        start_next = 1'b0;
        gap_left = pick_gap();
      end
      if (!start_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() != 0 &&
                     !(request_q[0].wait_idle && expected_replies.size() != 0)) begin
          // Hold a draining request back until the table has answered everything
          in_flight = request_q.pop_front();
          req_type <= in_flight.op;
          key <= in_flight.k;
          value <= in_flight.v;
          start_next = 1'b1;
        end
      end
      start <= start_next;
    end
  end

  // Monitor: every done pulse must match the oldest prediction field by field
  always @(posedge clk) begin
    if (!rst && done) begin
      reply_count++;
      status_count[status]++;
      if (found) hit_count++;
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected reply status=%0d found=%0d read_value=%h",
                                  status, found, read_value));
      end else begin
        if (status != expected_replies[0].st)
          report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                    reply_count, status, expected_replies[0].st));
        if (found != expected_replies[0].hit)
          report_mismatch($sformatf("reply %0d found %0d, want %0d",
                                    reply_count, found, expected_replies[0].hit));
        if (read_value != expected_replies[0].rd)
          report_mismatch($sformatf("reply %0d read_value %h, want %h",
                                    reply_count, read_value, expected_replies[0].rd));
        void'(expected_replies.pop_front());
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic signed [KEY_W-1:0] k;
    logic [KEY_W-1:0]        lane;
    int                      roll;
    op_t                     op;

    // Directed: misses on an empty table, duplicate insert, hit paths,
    // fill one bucket to overflow (including the most negative key and
    // keys of both signs), reuse of a freed way, extreme values.
    queue_request(OP_GET,    32'sd0, 32'sd0, 1'b0);
    queue_request(OP_REMOVE, 32'sd0, 32'sd0, 1'b0);
    queue_request(OP_UPDATE, 32'sd0, 32'sd3, 1'b0);
    queue_request(OP_INSERT, 32'sd0, 32'sd1, 1'b0);
    queue_request(OP_INSERT, 32'sd0, 32'sd2, 1'b0);
    queue_request(OP_GET,    32'sd0, 32'sd0, 1'b0);
    queue_request(OP_UPDATE, 32'sd0, 32'sh7fff_ffff, 1'b0);
    queue_request(OP_GET,    32'sd0, 32'sd0, 1'b0);
    queue_request(OP_INSERT, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    queue_request(OP_INSERT, 32'sd16, -32'sd1, 1'b0);
    queue_request(OP_INSERT, -32'sd16, 32'sd0, 1'b0);
    queue_request(OP_INSERT, 32'sd32, 32'sd5, 1'b0);
    queue_request(OP_GET,    32'sh8000_0000, 32'sd0, 1'b0);
    queue_request(OP_GET,    -32'sd16, 32'sd0, 1'b0);
    queue_request(OP_INSERT, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
    queue_request(OP_GET,    32'sh7fff_ffff, 32'sd0, 1'b0);
    queue_request(OP_REMOVE, 32'sd16, 32'sd0, 1'b0);
    queue_request(OP_GET,    32'sd16, 32'sd0, 1'b0);
    queue_request(OP_INSERT, 32'sd48, 32'sd7, 1'b0);
    queue_request(OP_INSERT, 32'sd64, 32'sd8, 1'b0);
    queue_request(OP_REMOVE, 32'sd0, 32'sd0, 1'b0);
    queue_request(OP_GET,    32'sd0, 32'sd0, 1'b0);
    queue_request(OP_UPDATE, -32'sd16, 32'sd123, 1'b0);
    queue_request(OP_GET,    -32'sd16, 32'sd0, 1'b0);
    queue_request(OP_INSERT, -32'sd1, 32'sd9, 1'b0);

    // Key pool: half crowd into three buckets so ways fill and overflow,
    // the rest are arbitrary, but the extremes replace the last four of them.
    for (int i = 0; i < 48; i++) begin
      if (i < 24) begin
        lane = ($urandom() & 32'h0fff_fff0) | 32'($urandom_range(0, 2));
        key_pool[i] = $urandom_range(0, 1) ? -$signed(lane) : $signed(lane);
      end else begin
        key_pool[i] = $urandom();
      end
    end
    key_pool[44] = 32'sh8000_0000;
    key_pool[45] = 32'sh7fff_ffff;
    key_pool[46] = 32'sd0;
    key_pool[47] = -32'sd1;

    // Random: mostly pool keys so inserts, hits and removes interact;
    // the first one drains the table before it goes.
    for (int n = 0; n < 925; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 35)      op = OP_INSERT;
      else if (roll < 55) op = OP_REMOVE;
      else if (roll < 80) op = OP_GET;
      else                op = OP_UPDATE;
      k = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 47)] : $signed($urandom());
      queue_request(op, k, $signed($urandom()), (n == 0) || ($urandom_range(0, 99) == 0));
    end

    // Wait for the last transfer and its reply, then let the pipe settle
    do @(posedge clk);
    while (request_q.size() != 0 || start || expected_replies.size() != 0);
    repeat (20) @(posedge clk);

    $display("covered %0d requests (insert %0d, remove %0d, get %0d, update %0d), %0d replies",
             sent_count, op_count[OP_INSERT], op_count[OP_REMOVE], op_count[OP_GET],
             op_count[OP_UPDATE], reply_count);
    $display("statuses: ok %0d, not found %0d, present %0d, full %0d; key hits %0d",
             status_count[ST_OK], status_count[ST_NOT_FOUND], status_count[ST_PRESENT],
             status_count[ST_FULL], hit_count);
    if (error_count == 0) begin
      $display("[bucketed_hash_table_top] OK");
    end else begin
      $display("[bucketed_hash_table_top] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d requests queued, %0d replies outstanding",
             request_q.size(), expected_replies.size());
    $display("[bucketed_hash_table_top] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/bht_pkg.sv
hw/rtl/bht_ram.sv
hw/rtl/bucketed_hash_table_top.sv
hw/rtl/bht_checker.sv
tb/testbench.sv
